// ===== rtl/core/rcfr_pkg.sv =====
// Shared types, constants and register codes for the RC command frame receiver.
`timescale 1ns / 1ps

package rcfr_pkg;

  localparam int CHANNELS      = 8;
  localparam int HEADER_BYTES  = 3;
  localparam int ALT_HOLD_MODE = 2;
  localparam int MANUAL_MODE   = 1;

  localparam int CH_IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int MAX_RES  = 4;
  localparam int RES_CW   = $clog2(MAX_RES + 1);
  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W    = $clog2(FIFO_DEPTH);
  localparam int CNT_W    = $clog2(FIFO_DEPTH + 1);

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic [15:0] CENTER_PULSE = 16'd1500;
  localparam logic [15:0] HB_VERSION   = 16'd1;

  // operation codes (input tuser)
  localparam logic OP_RX   = 1'b0;
  localparam logic OP_READ = 1'b1;

  // result kinds (output tuser)
  localparam logic KIND_HEARTBEAT = 1'b0;
  localparam logic KIND_CHANNEL   = 1'b1;

  // register indexes
  localparam logic [2:0] REG_START_BYTE  = 3'd0;
  localparam logic [2:0] REG_RC_CODE     = 3'd1;
  localparam logic [2:0] REG_MODE_CODE   = 3'd2;
  localparam logic [2:0] REG_MAX_MODE    = 3'd3;
  localparam logic [2:0] REG_BUTTON_CH   = 3'd4;
  localparam logic [2:0] REG_ALT_PULSE   = 3'd5;
  localparam logic [2:0] REG_MAN_PULSE   = 3'd6;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  rc_update_code;
    logic [7:0]  mode_code;
    logic [7:0]  max_mode;
    logic [2:0]  button_channel;
    logic [15:0] alt_hold_pulse;
    logic [15:0] manual_pulse;
  } rcfr_cfg_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] value;
    logic        last;
    logic [7:0]  mode;
  } rcfr_res_t;

endpackage

// ===== rtl/core/rcfr_regs.sv =====
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module rcfr_regs
  import rcfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output rcfr_cfg_t         cfg_o
);

  rcfr_cfg_t  cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_idx    = cfg_paddr[4:2];
  assign cfg_o      = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte     <= 8'd254;
      cfg_r.rc_update_code <= 8'd1;
      cfg_r.mode_code      <= 8'd2;
      cfg_r.max_mode       <= 8'd7;
      cfg_r.button_channel <= 3'd4;
      cfg_r.alt_hold_pulse <= 16'd1500;
      cfg_r.manual_pulse   <= 16'd1000;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_START_BYTE: cfg_r.start_byte     <= cfg_pwdata[7:0];
        REG_RC_CODE:    cfg_r.rc_update_code <= cfg_pwdata[7:0];
        REG_MODE_CODE:  cfg_r.mode_code      <= cfg_pwdata[7:0];
        REG_MAX_MODE:   cfg_r.max_mode       <= cfg_pwdata[7:0];
        REG_BUTTON_CH:  cfg_r.button_channel <= cfg_pwdata[2:0];
        REG_ALT_PULSE:  cfg_r.alt_hold_pulse <= cfg_pwdata[15:0];
        REG_MAN_PULSE:  cfg_r.manual_pulse   <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_START_BYTE: cfg_prdata = {24'd0, cfg_r.start_byte};
      REG_RC_CODE:    cfg_prdata = {24'd0, cfg_r.rc_update_code};
      REG_MODE_CODE:  cfg_prdata = {24'd0, cfg_r.mode_code};
      REG_MAX_MODE:   cfg_prdata = {24'd0, cfg_r.max_mode};
      REG_BUTTON_CH:  cfg_prdata = {29'd0, cfg_r.button_channel};
      REG_ALT_PULSE:  cfg_prdata = {16'd0, cfg_r.alt_hold_pulse};
      REG_MAN_PULSE:  cfg_prdata = {16'd0, cfg_r.manual_pulse};
      default:        cfg_prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/rcfr_parser.sv =====
// Input word register, frame parser, channel state and result generation.
`timescale 1ns / 1ps

module rcfr_parser
  import rcfr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_take,
  input  logic                    in_op,
  input  logic [7:0]              in_byte,
  input  logic [2:0]              in_idx,
  input  rcfr_cfg_t               cfg,
  output logic                    pend_o,
  output rcfr_res_t [MAX_RES-1:0] res_o,
  output logic [RES_CW-1:0]       res_cnt_o
);

  // input register
  logic       pend_r;
  logic       op_r;
  logic [7:0] byte_r;
  logic [2:0] idx_r;

  // parser state
  logic        in_frame_r,  in_frame_nxt;
  logic [8:0]  count_r,     count_nxt;
  logic [7:0]  plen_r,      plen_nxt;
  logic [7:0]  cmd_r,       cmd_nxt;
  logic [7:0]  arg_r,       arg_nxt;
  logic [7:0]  mode_r,      mode_nxt;
  logic [15:0] staged_r [CHANNELS];
  logic [15:0] staged_nxt [CHANNELS];
  logic [15:0] chv_r [CHANNELS];
  logic [15:0] chv_nxt [CHANNELS];

  assign pend_o = pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r   <= in_op;
      byte_r <= in_byte;
      idx_r  <= in_idx;
    end
  end

  always_comb begin
    logic [8:0]  pos;
    logic [8:0]  off;
    logic [7:0]  ch_sel;
    logic [7:0]  cmd_eff;
    logic [7:0]  arg_eff;
    logic [8:0]  total;
    logic [8:0]  n_cpy;
    logic [15:0] rd_val;

    in_frame_nxt = in_frame_r;
    count_nxt    = count_r;
    plen_nxt     = plen_r;
    cmd_nxt      = cmd_r;
    arg_nxt      = arg_r;
    mode_nxt     = mode_r;
    for (int i = 0; i < CHANNELS; i++) begin
      staged_nxt[i] = staged_r[i];
      chv_nxt[i]    = chv_r[i];
    end
    res_o     = '0;
    res_cnt_o = '0;

    pos     = count_r;
    off     = count_r - 9'd4;
    ch_sel  = off[8:1];
    cmd_eff = cmd_r;
    arg_eff = arg_r;
    total   = {1'b0, plen_r} + 9'(HEADER_BYTES);
    n_cpy   = '0;
    rd_val  = '0;

    if (pend_r) begin
      if (op_r == OP_READ) begin
        if ({5'd0, idx_r} < 8'(CHANNELS)) begin
          rd_val = chv_r[CH_IW'(idx_r)];
        end
        res_o[0]  = '{kind: KIND_CHANNEL, value: rd_val, last: 1'b1, mode: mode_r};
        res_cnt_o = RES_CW'(1);
      end else if (!in_frame_r) begin
        if (byte_r == cfg.start_byte) begin
          in_frame_nxt = 1'b1;
          count_nxt    = 9'd1;
          plen_nxt     = '0;
          cmd_nxt      = '0;
          arg_nxt      = '0;
        end
      end else begin
        if (pos == 9'd2) begin
          cmd_eff = byte_r;
        end else if (pos == 9'd3) begin
          arg_eff = byte_r;
        end else if (pos >= 9'd4 && ch_sel < 8'(CHANNELS)) begin
          // little-endian pair: even offset is the low byte
          if (!off[0]) begin
            staged_nxt[CH_IW'(ch_sel)][7:0]  = byte_r;
          end else begin
            staged_nxt[CH_IW'(ch_sel)][15:8] = byte_r;
          end
        end
        cmd_nxt   = cmd_eff;
        arg_nxt   = arg_eff;
        count_nxt = pos + 9'd1;
        if (count_nxt == 9'd2) begin
          plen_nxt = byte_r;
        end else if (count_nxt == total) begin
          in_frame_nxt = 1'b0;
          if (cmd_eff == cfg.rc_update_code) begin
            n_cpy = (arg_eff > 8'(CHANNELS)) ? 9'(CHANNELS) : {1'b0, arg_eff};
            // only channels with both bytes inside this frame
            for (int i = 0; i < CHANNELS; i++) begin
              if (9'(i) < n_cpy && 9'(2 * i + 6) <= total) begin
                chv_nxt[i] = staged_nxt[i];
              end
            end
          end else if (cmd_eff == cfg.mode_code && arg_eff <= cfg.max_mode) begin
            mode_nxt = arg_eff;
            if ({5'd0, cfg.button_channel} < 8'(CHANNELS)) begin
              if (arg_eff == 8'(ALT_HOLD_MODE)) begin
                chv_nxt[CH_IW'(cfg.button_channel)] = cfg.alt_hold_pulse;
              end else if (arg_eff == 8'(MANUAL_MODE)) begin
                chv_nxt[CH_IW'(cfg.button_channel)] = cfg.manual_pulse;
              end
            end
            res_o[0] = '{kind: KIND_HEARTBEAT, value: {8'd0, cfg.start_byte},
                         last: 1'b0, mode: arg_eff};
            res_o[1] = '{kind: KIND_HEARTBEAT, value: HB_VERSION,
                         last: 1'b0, mode: arg_eff};
            res_o[2] = '{kind: KIND_HEARTBEAT, value: {8'd0, cfg.mode_code},
                         last: 1'b0, mode: arg_eff};
            res_o[3] = '{kind: KIND_HEARTBEAT, value: {8'd0, arg_eff},
                         last: 1'b1, mode: arg_eff};
            res_cnt_o = RES_CW'(MAX_RES);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      count_r    <= '0;
      plen_r     <= '0;
      cmd_r      <= '0;
      arg_r      <= '0;
      mode_r     <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        chv_r[i] <= CENTER_PULSE;
      end
    end else begin
      in_frame_r <= in_frame_nxt;
      count_r    <= count_nxt;
      plen_r     <= plen_nxt;
      cmd_r      <= cmd_nxt;
      arg_r      <= arg_nxt;
      mode_r     <= mode_nxt;
      for (int i = 0; i < CHANNELS; i++) begin
        chv_r[i] <= chv_nxt[i];
      end
    end
  end

  // not reset and may keep older frames' bytes; read only after written this frame
  always_ff @(posedge clk) begin
    for (int i = 0; i < CHANNELS; i++) begin
      staged_r[i] <= staged_nxt[i];
    end
  end

endmodule

// ===== rtl/core/rcfr_out_fifo.sv =====
// Result queue: takes up to four results a cycle, hands out one a cycle when popped.
`timescale 1ns / 1ps

module rcfr_out_fifo
  import rcfr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  rcfr_res_t [MAX_RES-1:0] push_i,
  input  logic [RES_CW-1:0]       push_cnt_i,
  input  logic                    pop_i,
  output rcfr_res_t               head_o,
  output logic                    valid_o,
  output logic [CNT_W-1:0]        count_o
);

  rcfr_res_t          mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r,  count_nxt;
  logic               pop;

  assign valid_o = (count_r != '0);
  assign pop     = pop_i & valid_o;
  assign head_o  = mem_r[rd_ptr_r];
  assign count_o = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push_cnt_i);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + CNT_W'(push_cnt_i) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (RES_CW'(k) < push_cnt_i) begin
        mem_r[wr_ptr_r + PTR_W'(k)] <= push_i[k];
      end
    end
  end

endmodule

// ===== rtl/core/rc_command_frame_receiver_top.sv =====
// Top level of the RC command frame receiver.
//
//  channel  dir  handshake               payload
//  in_      in   in_tvalid / in_tready   tuser: operation; tdata: rx_byte, channel_index
//  out_     out  out_tvalid / out_tready tuser: result_kind; tlast: result_last;
//                                        tdata: result_value, current_mode
//  cfg_     in   psel/penable/pwrite     7 registers at byte address 4*i, pready tied high
//
// A word is parsed in the cycle after it is taken and its results are written into a
// 16-deep result queue at the end of that cycle; one word per cycle is taken as long
// as the queue has room for the worst case (four results) of words in flight. Results
// leave one per cycle while out_tready is high. A mode frame's end yields four results
// if its mode is in range, so mode frames drain at the output's one-word-per-cycle rate.
// Reset is synchronous, active low; channel values reset to 1500 each.
`timescale 1ns / 1ps

module rc_command_frame_receiver_top
  import rcfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,   // [7:0] rx_byte, [10:8] channel_index, rest zero
  input  logic              in_tuser,   // [0] operation
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,  // [15:0] result_value, [23:16] current_mode
  output logic              out_tuser,  // [0] result_kind
  output logic              out_tlast,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  rcfr_cfg_t                cfg;
  rcfr_res_t [MAX_RES-1:0]  res;
  logic [RES_CW-1:0]        res_cnt;
  logic                     pend;
  rcfr_res_t                head;
  logic [CNT_W-1:0]         q_count;
  logic                     in_take;
  logic [CNT_W+1:0]         q_need;

  rcfr_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  // reserve worst-case room for the word being parsed and the one arriving
  assign q_need    = (CNT_W+2)'(q_count) + (pend ? (CNT_W+2)'(MAX_RES) : '0)
                   + (CNT_W+2)'(MAX_RES);
  assign in_tready = (q_need <= (CNT_W+2)'(FIFO_DEPTH));
  assign in_take   = in_tvalid & in_tready;

  rcfr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_take   (in_take),
    .in_op     (in_tuser),
    .in_byte   (in_tdata[7:0]),
    .in_idx    (in_tdata[10:8]),
    .cfg       (cfg),
    .pend_o    (pend),
    .res_o     (res),
    .res_cnt_o (res_cnt)
  );

  rcfr_out_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (res),
    .push_cnt_i (res_cnt),
    .pop_i      (out_tready),
    .head_o     (head),
    .valid_o    (out_tvalid),
    .count_o    (q_count)
  );

  assign out_tdata = {head.mode, head.value};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_take_parses: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> pend)
    else $error("taken word not parsed next cycle");

  a_idle_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    !pend |-> res_cnt == '0)
    else $error("results pushed without a word in flight");

  a_read_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_CHANNEL |-> out_tlast)
    else $error("channel read result not marked last");

endmodule

// ===== verif/rc_command_frame_receiver_checker.sv =====
// Checker for the RC command frame receiver: predicts results from accepted words and compares.
`timescale 1ns / 1ps

module rc_command_frame_receiver_checker
  import rcfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [15:0]       in_tdata,   // [7:0] rx_byte, [10:8] channel_index
  input  logic              in_tuser,   // [0] operation
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [23:0]       out_tdata,  // [15:0] result_value, [23:16] current_mode
  input  logic              out_tuser,  // [0] result_kind
  input  logic              out_tlast,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic              cfg_pready,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output int                mismatches,
  output int                outstanding
);

  localparam rcfr_cfg_t CFG_RESET = '{
    start_byte:     8'd254,
    rc_update_code: 8'd1,
    mode_code:      8'd2,
    max_mode:       8'd7,
    button_channel: 3'd4,
    alt_hold_pulse: 16'd1500,
    manual_pulse:   16'd1000
  };

  rcfr_cfg_t   regs;
  logic        framing;
  logic [8:0]  pos_cnt;
  logic [7:0]  frame_len;
  logic [7:0]  cmd_byte;
  logic [7:0]  arg_byte;
  logic [7:0]  op_mode;
  logic [15:0] staged [CHANNELS];
  logic [15:0] chan_val [CHANNELS];
  rcfr_res_t   result_q[$];

  task automatic queue_result(input logic kind, input logic [15:0] value, input logic last);
    rcfr_res_t r;
    r.kind  = kind;
    r.value = value;
    r.last  = last;
    r.mode  = op_mode;
    result_q.push_back(r);
  endtask

  task automatic run_command();
    int n;
    int total;
    total = int'(frame_len) + HEADER_BYTES;
    if (cmd_byte == regs.rc_update_code) begin
      n = (arg_byte > CHANNELS) ? CHANNELS : int'(arg_byte);
      // only channels whose both bytes were inside this frame get copied
      for (int i = 0; i < n; i++)
        if (2 * i + 6 <= total) chan_val[i] = staged[i];
    end else if (cmd_byte == regs.mode_code && arg_byte <= regs.max_mode) begin
      op_mode = arg_byte;
      if (regs.button_channel < CHANNELS) begin
        if (op_mode == ALT_HOLD_MODE)
          chan_val[regs.button_channel] = regs.alt_hold_pulse;
        else if (op_mode == MANUAL_MODE)
          chan_val[regs.button_channel] = regs.manual_pulse;
      end
      queue_result(KIND_HEARTBEAT, {8'd0, regs.start_byte}, 1'b0);
      queue_result(KIND_HEARTBEAT, HB_VERSION, 1'b0);
      queue_result(KIND_HEARTBEAT, {8'd0, regs.mode_code}, 1'b0);
      queue_result(KIND_HEARTBEAT, {8'd0, op_mode}, 1'b1);
    end
  endtask

  task automatic take_word(input logic op, input logic [7:0] b, input logic [2:0] idx);
    int ch;
    logic [8:0] p;
    if (op == OP_READ) begin
      queue_result(KIND_CHANNEL, (idx < CHANNELS) ? chan_val[idx] : 16'd0, 1'b1);
    end else if (!framing) begin
      if (b == regs.start_byte) begin
        framing   = 1'b1;
        pos_cnt   = 9'd1;
        frame_len = 8'd0;
        cmd_byte  = 8'd0;
        arg_byte  = 8'd0;
      end
    end else begin
      p = pos_cnt;
      if (p == 9'd2) begin
        cmd_byte = b;
      end else if (p == 9'd3) begin
        arg_byte = b;
      end else if (p >= 9'd4) begin
        ch = (int'(p) - 4) / 2;
        if (ch < CHANNELS) begin
          if (!p[0]) staged[ch][7:0] = b;
          else staged[ch][15:8] = b;
        end
      end
      pos_cnt = p + 9'd1;
      if (pos_cnt == 9'd2) begin
        frame_len = b;
      end else if (int'(pos_cnt) == int'(frame_len) + HEADER_BYTES) begin
        framing = 1'b0;
        run_command();
      end
    end
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    rcfr_res_t want;
    if (!rst_n) begin
      regs      = CFG_RESET;
      framing   = 1'b0;
      pos_cnt   = 9'd0;
      frame_len = 8'd0;
      cmd_byte  = 8'd0;
      arg_byte  = 8'd0;
      op_mode   = 8'd0;
      for (int i = 0; i < CHANNELS; i++) begin
        staged[i]   = 16'd0;
        chan_val[i] = CENTER_PULSE;
      end
      result_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[CFG_AW-1:2])
          REG_START_BYTE: regs.start_byte     = cfg_pwdata[7:0];
          REG_RC_CODE:    regs.rc_update_code = cfg_pwdata[7:0];
          REG_MODE_CODE:  regs.mode_code      = cfg_pwdata[7:0];
          REG_MAX_MODE:   regs.max_mode       = cfg_pwdata[7:0];
          REG_BUTTON_CH:  regs.button_channel = cfg_pwdata[2:0];
          REG_ALT_PULSE:  regs.alt_hold_pulse = cfg_pwdata[15:0];
          REG_MAN_PULSE:  regs.manual_pulse   = cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        take_word(in_tuser, in_tdata[7:0], in_tdata[10:8]);
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          $error("result word with nothing expected: value %0d mode %0d",
                 out_tdata[15:0], out_tdata[23:16]);
          mismatches++;
        end else begin
          want = result_q.pop_front();
          compare_field("result_kind", int'(want.kind), int'(out_tuser));
          compare_field("result_value", int'(want.value), int'(out_tdata[15:0]));
          compare_field("result_last", int'(want.last), int'(out_tlast));
          compare_field("current_mode", int'(want.mode), int'(out_tdata[23:16]));
        end
      end
    end
    outstanding = result_q.size();
  end

endmodule

// ===== verif/rc_command_frame_receiver_top_tb.sv =====
// Testbench top for the RC command frame receiver: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module rc_command_frame_receiver_top_tb;
  import rcfr_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [15:0]       in_tdata = '0;
  logic              in_tuser = OP_RX;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [23:0]       out_tdata;
  logic              out_tuser;
  logic              out_tlast;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int mismatches;
  int outstanding;
  int snd_idle = 0;
  int rcv_idle = 0;
  int sent_items;

  // values currently programmed, used to build well-formed frames
  logic [7:0] cur_start = 8'd254;
  logic [7:0] cur_rc    = 8'd1;
  logic [7:0] cur_mode  = 8'd2;
  logic [7:0] cur_max   = 8'd7;
  logic [7:0] frame_bytes[$];

  rc_command_frame_receiver_top uut (.*);

  rc_command_frame_receiver_checker u_check (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_pready, .cfg_paddr, .cfg_pwdata,
    .mismatches, .outstanding
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rcv_idle);
  end

  // entered and left at a falling edge; tvalid stays high into the next word
  task automatic send_word(input logic op, input logic [7:0] b, input logic [2:0] idx);
    while ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'd0, idx, b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic push_frame(input bit with_reads, input int count);
    for (int i = 0; i < count && i < frame_bytes.size(); i++) begin
      if (with_reads && $urandom_range(99) < 15) begin
        send_word(OP_READ, 8'($urandom_range(255)), 3'($urandom_range(7)));
        sent_items++;
      end
      send_word(OP_RX, frame_bytes[i], 3'($urandom_range(7)));
      sent_items++;
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input logic [7:0] s, input logic [7:0] rc, input logic [7:0] md,
                           input logic [7:0] mx, input logic [2:0] btn,
                           input logic [15:0] alt, input logic [15:0] man);
    write_reg(REG_START_BYTE, 32'(s));
    write_reg(REG_RC_CODE, 32'(rc));
    write_reg(REG_MODE_CODE, 32'(md));
    write_reg(REG_MAX_MODE, 32'(mx));
    write_reg(REG_BUTTON_CH, 32'(btn));
    write_reg(REG_ALT_PULSE, 32'(alt));
    write_reg(REG_MAN_PULSE, 32'(man));
    cur_start = s;
    cur_rc    = rc;
    cur_mode  = md;
    cur_max   = mx;
  endtask

  // wait out every expected word plus the parse pipeline
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic send_frame();
    int sel;
    int len;
    int nch;
    int count;
    logic [7:0] cmd;
    logic [7:0] arg;
    logic [7:0] noise;
    sel = $urandom_range(99);
    if (sel >= 92) begin
      // hunting noise, kept off the start marker so framing is not thrown off
      repeat ($urandom_range(1, 4)) begin
        noise = 8'($urandom_range(255));
        if (noise == cur_start) noise = ~noise;
        send_word(OP_RX, noise, 3'($urandom_range(7)));
      end
      return;
    end
    if (sel < 40) begin
      nch = $urandom_range(10);
      len = 1 + 2 * nch + $urandom_range(1);
      if ($urandom_range(49) == 0) len = $urandom_range(255);
      cmd = cur_rc;
      arg = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'(nch);
    end else if (sel < 75) begin
      len = ($urandom_range(9) == 0) ? 0 : 1 + $urandom_range(2);
      cmd = cur_mode;
      case ($urandom_range(3))
        0:       arg = 8'(ALT_HOLD_MODE);
        1:       arg = 8'(MANUAL_MODE);
        2:       arg = 8'($urandom_range(cur_max));
        default: arg = 8'($urandom_range(255));
      endcase
    end else if (sel < 85) begin
      len = $urandom_range(6);
      cmd = 8'($urandom_range(255));
      arg = 8'($urandom_range(255));
    end else begin
      // short frame: zero length ends before the argument byte, length one after it
      len = $urandom_range(1) ? 0 : 1;
      cmd = $urandom_range(1) ? cur_mode : cur_rc;
      arg = 8'($urandom_range(255));
    end
    frame_bytes.delete();
    frame_bytes.push_back(cur_start);
    frame_bytes.push_back(8'(len));
    frame_bytes.push_back(cmd);
    frame_bytes.push_back(arg);
    while (frame_bytes.size() < len + HEADER_BYTES)
      frame_bytes.push_back(8'($urandom_range(255)));
    count = len + HEADER_BYTES;
    // a few broken frames that stop early and desync the parser
    if ($urandom_range(24) == 0) count = $urandom_range(1, count - 1);
    push_frame(1'b1, count);
  endtask

  task automatic random_phase(input int budget);
    sent_items = 0;
    while (sent_items < budget) send_frame();
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    snd_idle = 14;
    rcv_idle = 76;
    send_word(OP_READ, 8'hFF, 3'd0);
    send_word(OP_RX, 8'h00, 3'd7);
    frame_bytes = '{cur_start, 8'd1, cur_mode, 8'(MANUAL_MODE)};
    push_frame(1'b0, 4);
    send_word(OP_READ, 8'h00, 3'd4);
    // mode above the limit is dropped silently
    frame_bytes = '{cur_start, 8'd1, cur_mode, cur_max + 8'd1};
    push_frame(1'b0, 4);
    // two channels, both carried whole; length 6 leaves the frame a byte short
    frame_bytes = '{cur_start, 8'd6, cur_rc, 8'd2, 8'h34, 8'h12, 8'hFF, 8'hFF};
    push_frame(1'b0, 8);
    send_word(OP_READ, 8'h5A, 3'd1);
    // zero length, but its start byte ends the frame above; the rest is hunted over
    frame_bytes = '{cur_start, 8'd0, cur_mode};
    push_frame(1'b0, 3);
    send_word(OP_READ, 8'hA5, 3'd7);
    drain();

    configure(8'h00, 8'hFF, 8'h00, 8'hFF, 3'd0, 16'hFFFF, 16'h0000);
    random_phase(160);

    snd_idle = 76;
    rcv_idle = 14;
    // equal command codes: update wins
    configure(8'hFF, 8'h5A, 8'h5A, 8'h00, 3'd7, 16'h0000, 16'hFFFF);
    random_phase(160);

    snd_idle = 0;
    rcv_idle = 0;
    begin : last_setting
      logic [7:0] rc;
      rc = 8'($urandom_range(255));
      configure(8'($urandom_range(255)), rc, rc ^ 8'($urandom_range(1, 255)),
                8'($urandom_range(2, 254)), 3'($urandom_range(7)),
                16'($urandom_range(65535)), 16'($urandom_range(65535)));
    end
    random_phase(160);

    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
